@@ hdl/xcsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcsd_pkg
// Character codes, verdict codes and helpers for the sentence deframer.
// ----------------------------------------------------------------------------
package xcsd_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    localparam int MIN_LEN = 4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_DOLLAR = 3'd2,
        ST_NO_STAR   = 3'd3,
        ST_NO_HEX    = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_MISMATCH  = 3'd6
    } status_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_of(input logic [7:0] b);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            d.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            d.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            d.value = 4'(b - 8'h37);
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ hdl/xcsd_rx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcsd_rx_if
// Byte channel into the deframer: one received byte per item.
// ----------------------------------------------------------------------------
interface xcsd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/xcsd_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcsd_res_if
// Verdict channel out of the deframer: one item per finished line.
// ----------------------------------------------------------------------------
interface xcsd_res_if;
    logic       valid;
    logic       ready;
    logic       frame_ok;
    logic [2:0] status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [8:0] payload_fields;
    logic [8:0] line_length;

    modport source (output valid, output frame_ok, output status, output computed_sum,
                    output received_sum, output payload_fields, output line_length,
                    input ready);
    modport sink   (input valid, input frame_ok, input status, input computed_sum,
                    input received_sum, input payload_fields, input line_length,
                    output ready);
endinterface

@@ hdl/xor_checked_sentence_deframer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_sentence_deframer_unit
// Line deframer for "$body*HH" sentences with an XOR checksum check.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle. Each accepted byte lands in an input register
// and is folded into the line state in the next cycle, so a steady stream
// runs at one byte per clock. A line ends at a newline or after MAX_LINE
// bytes; when that byte leaves the input register it loads one verdict item
// into the output register, where it is held while the next line's bytes keep
// flowing. Only a line-ending byte that meets a full, stalled output register
// waits.
module xor_checked_sentence_deframer_unit #(
    parameter int MAX_LINE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    xcsd_rx_if.sink    rx,
    xcsd_res_if.source res
);
    import xcsd_pkg::*;

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int WW = (CW + 1 > 10) ? CW + 1 : 10;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // line state
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          dollar_reg, dollar_next;
    logic [7:0]    xor_reg, xor_next;
    logic [7:0]    xor_star_reg, xor_star_next;
    logic          star_reg, star_next;
    logic [7:0]    hex_reg, hex_next;
    logic          hex_any_reg, hex_any_next;
    logic          hex_stop_reg, hex_stop_next;
    logic [CW-1:0] comma_reg, comma_next;
    logic [CW-1:0] comma_star_reg, comma_star_next;
    logic          body_reg, body_next;
    logic          last_comma_reg, last_comma_next;
    logic [CW-1:0] cr_reg, cr_next;
    logic          comma_end_reg, comma_end_next;

    // output register
    logic       out_valid_reg;
    logic       ok_reg;
    logic [2:0] status_reg;
    logic [7:0] csum_reg;
    logic [7:0] rsum_reg;
    logic [8:0] payload_reg;
    logic [8:0] len_reg;

    logic          is_nl;
    logic          line_end;
    logic          advance;
    logic          out_free;
    logic [CW-1:0] cnt_inc;
    logic [WW-1:0] len_w;
    logic [WW-1:0] tokens_w;
    logic [WW-1:0] payload_w;
    status_t       status_c;
    logic [7:0]    csum_c;
    logic [7:0]    rsum_c;
    hex_digit_t    digit;

    assign out_free = !out_valid_reg || res.ready;
    assign advance  = in_valid_reg && (!line_end || out_free);
    assign rx.ready = !in_valid_reg || advance;

    always_comb
    begin
        is_nl   = (in_byte_reg == CHAR_NL);
        cnt_inc = cnt_reg + CW'(1);
        digit   = hex_of(in_byte_reg);

        cnt_next        = cnt_inc;
        dollar_next     = dollar_reg;
        xor_next        = xor_reg;
        xor_star_next   = xor_star_reg;
        star_next       = star_reg;
        hex_next        = hex_reg;
        hex_any_next    = hex_any_reg;
        hex_stop_next   = hex_stop_reg;
        comma_next      = comma_reg;
        comma_star_next = comma_star_reg;
        body_next       = body_reg;
        last_comma_next = last_comma_reg;
        cr_next         = cr_reg;
        comma_end_next  = comma_end_reg;

        if (!is_nl)
        begin
            if (cnt_reg == '0)
            begin
                dollar_next = (in_byte_reg == CHAR_DOLLAR);
            end
            else
            begin
                if (in_byte_reg == CHAR_STAR)
                begin
                    star_next       = 1'b1;
                    xor_star_next   = xor_reg;
                    comma_star_next = comma_reg;
                    body_next       = (cnt_reg != CW'(1));
                    comma_end_next  = last_comma_reg;
                    hex_next        = 8'd0;
                    hex_any_next    = 1'b0;
                    hex_stop_next   = 1'b0;
                end
                else if (star_reg && !hex_stop_reg)
                begin
                    if (digit.is_hex)
                    begin
                        hex_next     = {hex_reg[3:0], digit.value};
                        hex_any_next = 1'b1;
                    end
                    else
                    begin
                        hex_stop_next = 1'b1;
                    end
                end
                xor_next = xor_reg ^ in_byte_reg;
                if (in_byte_reg == CHAR_COMMA)
                begin
                    comma_next = comma_reg + CW'(1);
                end
                last_comma_next = (in_byte_reg == CHAR_COMMA);
            end
            cr_next = (in_byte_reg == CHAR_CR) ? cr_reg + CW'(1) : '0;
        end

        line_end = is_nl || (WW'(cnt_inc) >= WW'(MAX_LINE));
    end

    // verdict for the line that this byte closes
    always_comb
    begin
        len_w     = WW'(cnt_inc) - WW'(is_nl) - WW'(cr_next);
        tokens_w  = body_next ? WW'(comma_star_next) + WW'(!comma_end_next) : '0;
        payload_w = (tokens_w > WW'(2)) ? tokens_w - WW'(2) : '0;
        csum_c    = 8'd0;
        rsum_c    = 8'd0;

        if (len_w < WW'(MIN_LEN))
        begin
            status_c  = ST_SHORT;
            payload_w = '0;
        end
        else if (!dollar_next)
        begin
            status_c  = ST_NO_DOLLAR;
            payload_w = '0;
        end
        else if (!star_next)
        begin
            status_c  = ST_NO_STAR;
            payload_w = '0;
        end
        else
        begin
            csum_c = xor_star_next;
            if (!hex_any_next)
            begin
                status_c = ST_NO_HEX;
            end
            else
            begin
                rsum_c = hex_next;
                if (hex_next != xor_star_next)
                begin
                    status_c = ST_MISMATCH;
                end
                else if (!body_next)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    status_c = ST_OK;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            dollar_reg     <= 1'b0;
            xor_reg        <= 8'd0;
            xor_star_reg   <= 8'd0;
            star_reg       <= 1'b0;
            hex_reg        <= 8'd0;
            hex_any_reg    <= 1'b0;
            hex_stop_reg   <= 1'b0;
            comma_reg      <= '0;
            comma_star_reg <= '0;
            body_reg       <= 1'b0;
            last_comma_reg <= 1'b0;
            cr_reg         <= '0;
            comma_end_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (line_end)
            begin
                // clear for the next line
                cnt_reg        <= '0;
                dollar_reg     <= 1'b0;
                xor_reg        <= 8'd0;
                xor_star_reg   <= 8'd0;
                star_reg       <= 1'b0;
                hex_reg        <= 8'd0;
                hex_any_reg    <= 1'b0;
                hex_stop_reg   <= 1'b0;
                comma_reg      <= '0;
                comma_star_reg <= '0;
                body_reg       <= 1'b0;
                last_comma_reg <= 1'b0;
                cr_reg         <= '0;
                comma_end_reg  <= 1'b0;
            end
            else
            begin
                cnt_reg        <= cnt_next;
                dollar_reg     <= dollar_next;
                xor_reg        <= xor_next;
                xor_star_reg   <= xor_star_next;
                star_reg       <= star_next;
                hex_reg        <= hex_next;
                hex_any_reg    <= hex_any_next;
                hex_stop_reg   <= hex_stop_next;
                comma_reg      <= comma_next;
                comma_star_reg <= comma_star_next;
                body_reg       <= body_next;
                last_comma_reg <= last_comma_next;
                cr_reg         <= cr_next;
                comma_end_reg  <= comma_end_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && line_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && line_end)
        begin
            ok_reg      <= (status_c == ST_OK);
            status_reg  <= status_c;
            csum_reg    <= csum_c;
            rsum_reg    <= rsum_c;
            payload_reg <= payload_w[8:0];
            len_reg     <= len_w[8:0];
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.frame_ok       = ok_reg;
    assign res.status         = status_reg;
    assign res.computed_sum   = csum_reg;
    assign res.received_sum   = rsum_reg;
    assign res.payload_fields = payload_reg;
    assign res.line_length    = len_reg;

endmodule
